// File: src/fan_speed_level_selector_unit_defines.svh
// assertion macros for the fan speed level selector
// no dependencies; included by the top level ahead of its assertions
`ifndef FAN_SPEED_LEVEL_SELECTOR_UNIT_DEFINES_SVH
`define FAN_SPEED_LEVEL_SELECTOR_UNIT_DEFINES_SVH

// condition must hold at the same edge as the trigger
`define FSLS_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("fsls check failed: same-cycle condition");

// condition must hold in the cycle after the trigger
`define FSLS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("fsls check failed: next-cycle condition");

`endif

// File: src/fsls_pkg.sv
// shared types and constants for the fan speed level selector
// no dependencies; imported by fsls_level_sel, the top level and the bench
package fsls_pkg;

  // sample window, depth must be a power of two
  localparam int WINDOW_DEPTH = 8;
  localparam int WIN_LOG2     = $clog2(WINDOW_DEPTH);
  localparam int SAMPLE_W     = 8;
  localparam int SUM_W        = SAMPLE_W + WIN_LOG2;

  // level table
  localparam int NUM_CFG_LEVELS = 4;
  localparam int NUM_LEVELS     = 4;
  localparam int LVL_W          = 3;
  localparam int LVL_IDX_W      = $clog2(NUM_CFG_LEVELS);
  localparam int HYSTERESIS     = 3;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [SAMPLE_W-1:0] byte_t;
  typedef logic [LVL_W-1:0]    level_t;
  typedef byte_t               lvl_tab_t [NUM_CFG_LEVELS];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_0 = 3'd0,
    CFG_THRESHOLD_1 = 3'd1,
    CFG_THRESHOLD_2 = 3'd2,
    CFG_THRESHOLD_3 = 3'd3,
    CFG_DUTY_0      = 3'd4,
    CFG_DUTY_1      = 3'd5,
    CFG_DUTY_2      = 3'd6,
    CFG_DUTY_3      = 3'd7
  } cfg_idx_t;

  localparam lvl_tab_t THR_RESET  = '{8'd93, 8'd104, 8'd116, 8'd163};
  localparam lvl_tab_t DUTY_RESET = '{8'd190, 8'd210, 8'd230, 8'd255};

endpackage

// File: src/fsls_level_sel.sv
// level selection with downward hysteresis
// depends on fsls_pkg
module fsls_level_sel
  import fsls_pkg::*;
(
  input  byte_t    mean,
  input  level_t   cur_level,
  input  lvl_tab_t thr,
  output level_t   next_level
);

  logic                 en;
  level_t               best;
  logic [LVL_IDX_W-1:0] cur_idx;
  level_t               cur_m1;
  byte_t                cur_thr;
  logic                 hold;

  // highest enabled level whose threshold the mean reaches
  always_comb begin
    en   = 1'b1;
    best = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      en = en & (thr[i] != '0);
      if (en && (mean >= thr[i])) begin
        best = LVL_W'(i + 1);
      end
    end
  end

  // refuse a drop while the current threshold is within the hysteresis band
  assign cur_m1  = cur_level - level_t'(1);
  assign cur_idx = cur_m1[LVL_IDX_W-1:0];
  assign cur_thr = thr[cur_idx];
  assign hold    = (best < cur_level) &&
                   ({1'b0, cur_thr} < ({1'b0, mean} + (SAMPLE_W+1)'(HYSTERESIS)));

  assign next_level = hold ? cur_level : best;

endmodule

// File: src/fan_speed_level_selector_unit.sv
// Fan speed level selector. Each accepted word carries one 8-bit temperature
// sample; the last 8 samples (zero after reset) form a moving window whose
// truncated mean picks the highest enabled fan level whose threshold it
// reaches, with a 3-code hysteresis band on the way down. One result word (level,
// duty, mean) comes out per sample, registered in the cycle after acceptance;
// a new sample is taken every cycle unless the output stalls, since the running
// sum, the four threshold compares and the hysteresis check all sit between the
// sample window and the output register. The user must write thresholds and
// duties through the cfg port only while no sample is in flight (not enforced).
// depends on fsls_pkg, fsls_level_sel and fan_speed_level_selector_unit_defines.svh
`include "fan_speed_level_selector_unit_defines.svh"

module fan_speed_level_selector_unit
  import fsls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LVL_W-1:0]      out_level,
  output logic [SAMPLE_W-1:0]   out_fan_duty,
  output logic [SAMPLE_W-1:0]   out_mean_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lvl_tab_t   thr_r;
  lvl_tab_t   duty_r;
  byte_t      win_r [WINDOW_DEPTH];
  logic [SUM_W-1:0] sum_r, sum_nxt;
  level_t     level_r, level_nxt;
  byte_t      duty_out_r, duty_out_nxt;
  byte_t      mean_r, mean_nxt;
  logic       out_valid_r;
  logic       in_fire;
  level_t     lvl_m1;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THR_RESET;
      duty_r <= DUTY_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_THRESHOLD_0: thr_r[0]  <= cfg_wdata;
        CFG_THRESHOLD_1: thr_r[1]  <= cfg_wdata;
        CFG_THRESHOLD_2: thr_r[2]  <= cfg_wdata;
        CFG_THRESHOLD_3: thr_r[3]  <= cfg_wdata;
        CFG_DUTY_0:      duty_r[0] <= cfg_wdata;
        CFG_DUTY_1:      duty_r[1] <= cfg_wdata;
        CFG_DUTY_2:      duty_r[2] <= cfg_wdata;
        CFG_DUTY_3:      duty_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // running sum: drop the oldest sample, add the new one
  assign sum_nxt  = sum_r - SUM_W'(win_r[WINDOW_DEPTH-1]) + SUM_W'(in_sample);
  assign mean_nxt = sum_nxt[SUM_W-1:WIN_LOG2];

  // level decision
  fsls_level_sel u_level_sel (
    .mean       (mean_nxt),
    .cur_level  (level_r),
    .thr        (thr_r),
    .next_level (level_nxt)
  );

  // duty of the chosen level, zero when off
  assign lvl_m1       = level_nxt - level_t'(1);
  assign duty_out_nxt = (level_nxt == '0) ? '0 : duty_r[lvl_m1[LVL_IDX_W-1:0]];

  // sample window as a shift line, newest at tap 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      sum_r   <= '0;
      level_r <= '0;
    end else if (in_fire) begin
      win_r[0] <= in_sample;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
      sum_r   <= sum_nxt;
      level_r <= level_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      duty_out_r <= duty_out_nxt;
      mean_r     <= mean_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_level      = level_r;
  assign out_fan_duty   = duty_out_r;
  assign out_mean_value = mean_r;

  // checks
  `FSLS_ASSERT_SAME(a_level_range, 1'b1, level_r <= LVL_W'(NUM_LEVELS))
  `FSLS_ASSERT_SAME(a_off_no_duty, out_valid_r && (level_r == '0), duty_out_r == '0)
  `FSLS_ASSERT_NEXT(a_fire_gives_out, in_fire, out_valid_r)
  `FSLS_ASSERT_NEXT(a_mean_matches_sum, in_fire, mean_r == sum_r[SUM_W-1:WIN_LOG2])

endmodule

// File: bench/fan_speed_level_selector_unit_test.sv
// self-checking bench for fan_speed_level_selector_unit: window mean, level pick, hysteresis
// depends on fsls_pkg and the unit's RTL; predicts every result word in-bench
module fan_speed_level_selector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fsls_pkg::*;

  typedef struct packed {
    level_t level;
    byte_t  duty;
    byte_t  mean;
  } fan_word_t;

  // clock, reset and block ports
  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  byte_t    in_sample = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  level_t   out_level;
  byte_t    out_fan_duty;
  byte_t    out_mean_value;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_THRESHOLD_0;
  byte_t    cfg_wdata = '0;

  // level predictor state and its copy of the registers
  byte_t             win_buf [WINDOW_DEPTH];
  logic [SUM_W-1:0]  win_total;
  logic [WIN_LOG2-1:0] win_ptr;
  level_t            fan_level;
  byte_t             thr_reg [NUM_CFG_LEVELS];
  byte_t             duty_reg [NUM_CFG_LEVELS];
  fan_word_t         fan_expected [$];

  // traffic shaping and bookkeeping
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int temp_now = 64;
  int temp_goal = 64;

  fan_speed_level_selector_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_level      (out_level),
    .out_fan_duty   (out_fan_duty),
    .out_mean_value (out_mean_value),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  always #1 clk = ~clk;

  // run limit
  initial begin
    #1_000_000;
    $display("fan_speed_level_selector_unit_test: errors");
    $finish;
  end

  // predictor back to its post-reset state
  task automatic reset_predictor();
    for (int i = 0; i < WINDOW_DEPTH; i++) win_buf[i] = '0;
    win_total = '0;
    win_ptr = '0;
    fan_level = '0;
    thr_reg = THR_RESET;
    duty_reg = DUTY_RESET;
  endtask

  // slide the window, pick the level, apply hysteresis on the way down
  function automatic fan_word_t predict_level(byte_t s);
    fan_word_t w;
    level_t best;
    int diff;
    best = '0;
    win_total = win_total - win_buf[win_ptr] + s;
    win_buf[win_ptr] = s;
    win_ptr = win_ptr + 1'b1;
    w.mean = byte_t'(win_total / WINDOW_DEPTH);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (thr_reg[i] == 0) break;
      if (w.mean >= thr_reg[i]) best = level_t'(i + 1);
    end
    if (best < fan_level) begin
      diff = int'(thr_reg[fan_level - 1]) - int'(w.mean);
      if (diff >= HYSTERESIS) fan_level = best;
    end else begin
      fan_level = best;
    end
    w.level = fan_level;
    w.duty = (fan_level != 0) ? duty_reg[fan_level - 1] : '0;
    return w;
  endfunction

  // temperature walk toward a moving goal, with noise and some wild samples
  function automatic byte_t next_sample();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 10) return $urandom_range(1) ? 8'hFF : 8'h00;
    if (pick < 25) return byte_t'($urandom_range(255));
    if (temp_now == temp_goal)
      temp_goal = ($urandom_range(4) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
    v = $urandom_range(6, 1);
    if (temp_goal > temp_now) temp_now = (temp_now + v > temp_goal) ? temp_goal : temp_now + v;
    else temp_now = (temp_now - v < temp_goal) ? temp_goal : temp_now - v;
    v = temp_now + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return byte_t'(v);
  endfunction

  // offer one sample word, hold it until accepted, then predict its result
  task automatic send_sample(input byte_t s);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    fan_expected.push_back(predict_level(s));
    words_sent++;
  endtask

  // stop offering and let every expected word come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (fan_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write, mirrored into the predictor
  task automatic cfg_write(input cfg_idx_t idx, input byte_t v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx < CFG_DUTY_0) thr_reg[idx - CFG_THRESHOLD_0] = v;
    else duty_reg[idx - CFG_DUTY_0] = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_levels(input lvl_tab_t thr, input lvl_tab_t duty);
    for (int i = 0; i < NUM_CFG_LEVELS; i++) begin
      cfg_write(cfg_idx_t'(CFG_THRESHOLD_0 + i), thr[i]);
      cfg_write(cfg_idx_t'(CFG_DUTY_0 + i), duty[i]);
    end
  endtask

  task automatic report(input string what, input int want, input int got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // compare one result word against the oldest prediction
  task automatic check_word();
    fan_word_t want;
    if (fan_expected.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result word with nothing expected, level %0d", $time, out_level);
    end else begin
      want = fan_expected.pop_front();
      words_checked++;
      if (out_level !== want.level) report("level", want.level, out_level);
      if (out_fan_duty !== want.duty) report("fan_duty", want.duty, out_fan_duty);
      if (out_mean_value !== want.mean) report("mean_value", want.mean, out_mean_value);
    end
  endtask

  // result side: check accepted words, stall at random or hold off on request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) check_word();
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // full ramp up and down, duty rewrite and a zeroed active threshold
  task automatic test_ramp_and_overrides();
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) send_sample(8'hFF);
    wait_drained();
    // duty change shows at once on the active level
    cfg_write(CFG_DUTY_3, 8'h5A);
    send_sample(8'hFF);
    wait_drained();
    // active threshold zeroed: the level must never drop
    cfg_write(CFG_THRESHOLD_3, 8'h00);
    repeat (8) send_sample(8'h00);
    wait_drained();
    cfg_write(CFG_THRESHOLD_3, THR_RESET[3]);
    send_sample(8'h00);
    send_sample(8'h80);
    send_sample(8'h7F);
    wait_drained();
  endtask

  // long receiver hold-off while words keep coming, then a full pause
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 40;
    repeat (30) send_sample(next_sample());
    wait_drained();
    repeat (20) send_sample(next_sample());
    wait_drained();
  endtask

  // random phases over register settings and idle patterns
  task automatic test_random_phases();
    lvl_tab_t thr;
    lvl_tab_t duty;
    int acc;
    for (int phase = 0; phase < 12; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      acc = $urandom_range(200, 1);
      for (int i = 0; i < NUM_CFG_LEVELS; i++) begin
        case (phase % 5)
          0: begin thr[i] = THR_RESET[i]; duty[i] = DUTY_RESET[i]; end
          1: begin thr[i] = 8'hFF; duty[i] = 8'hFF; end
          2: begin thr[i] = 8'h00; duty[i] = 8'h00; end
          3: begin
            thr[i] = byte_t'(acc);
            acc = acc + $urandom_range(40);
            if (acc > 255) acc = 255;
            duty[i] = byte_t'($urandom_range(255));
          end
          default: begin
            thr[i] = ($urandom_range(99) < 15) ? 8'h00 : byte_t'($urandom_range(255));
            duty[i] = byte_t'($urandom_range(255));
          end
        endcase
      end
      load_levels(thr, duty);
      repeat (157) send_sample(next_sample());
    end
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ramp_and_overrides();
    test_backpressure();
    test_random_phases();
    wait_drained();
    repeat (8) @(posedge clk);
    errors += fan_expected.size();
    $display("covered %0d samples and %0d result words: ramps, overrides, hold-off,",
             words_sent, words_checked);
    $display("and 12 random phases over threshold/duty settings and idle patterns");
    if (errors == 0) begin
      $display("fan_speed_level_selector_unit_test: clean");
    end else begin
      $display("fan_speed_level_selector_unit_test: errors");
    end
    $finish;
  end

endmodule
